// ===== design/spbl_pkg.sv =====
// Package for the sorted pair bound lookup block: sizes, codes and the
// structs passed between the sequencer, the table memories and the top level.
// No dependencies.
package spbl_pkg;

   localparam int MAX_PAIRS = 64;
   localparam int WORD_W    = 8;
   localparam int ENT_W     = 2 * WORD_W;
   localparam int AW        = $clog2(MAX_PAIRS);
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_QSRC   = 2'd2,
      ACT_QTGT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [WORD_W-1:0] source_word;
      logic [WORD_W-1:0] target_word;
      logic              rightmost;
   } req_item_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [WORD_W-1:0] aligned_word;
   } res_item_type;

   typedef struct packed {
      logic             wr_en;
      logic [AW-1:0]    wr_addr;
      logic [ENT_W-1:0] wr_data;
      logic             rd_en;
      logic [AW-1:0]    rd_addr;
   } ram_req_type;

endpackage

// ===== design/sorted_pair_bound_lookup.sv =====
// Sorted pair bound lookup: one item at a time. Clear and an insert into a
// full table go straight to the result. An insert shifts each larger entry
// up one place in each table in turn, then writes the new entry into the
// gap; a query scans its table from the front until the bound is settled
// or the scan runs past the last entry. Each table memory has a single read
// port and there is one shared comparator, so every entry shifted or
// scanned takes a read and then a compare. The result sits in an output
// register, so the next item is taken while it waits. Depends on spbl_pkg,
// spbl_seq, spbl_ram.
module sorted_pair_bound_lookup
   import spbl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [WORD_W-1:0] req_source_word,
   input  logic [WORD_W-1:0] req_target_word,
   input  logic              req_rightmost,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [WORD_W-1:0] rsp_aligned_word
);

   req_item_type      req_item;
   res_item_type      res_item;
   ram_req_type       src_ram_req;
   ram_req_type       tgt_ram_req;
   logic [ENT_W-1:0]  src_rd_data;
   logic [ENT_W-1:0]  tgt_rd_data;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [WORD_W-1:0] rsp_word_ff;

   assign req_item.action      = req_action;
   assign req_item.source_word = req_source_word;
   assign req_item.target_word = req_target_word;
   assign req_item.rightmost   = req_rightmost;

   assign out_free = !rsp_valid_ff || rsp_ready;

   spbl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .out_free    (out_free),
      .res_item    (res_item),
      .src_ram_req (src_ram_req),
      .tgt_ram_req (tgt_ram_req),
      .src_rd_data (src_rd_data),
      .tgt_rd_data (tgt_rd_data)
   );

   spbl_ram #(.DEPTH(MAX_PAIRS), .WIDTH(ENT_W)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_ram_req.wr_en),
      .wr_addr (src_ram_req.wr_addr),
      .wr_data (src_ram_req.wr_data),
      .rd_en   (src_ram_req.rd_en),
      .rd_addr (src_ram_req.rd_addr),
      .rd_data (src_rd_data)
   );

   spbl_ram #(.DEPTH(MAX_PAIRS), .WIDTH(ENT_W)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_ram_req.wr_en),
      .wr_addr (tgt_ram_req.wr_addr),
      .wr_data (tgt_ram_req.wr_data),
      .rd_en   (tgt_ram_req.rd_en),
      .rd_addr (tgt_ram_req.rd_addr),
      .rd_data (tgt_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_item.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_item.valid && out_free) begin
         rsp_status_ff <= res_item.status;
         rsp_word_ff   <= res_item.aligned_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_aligned_word = rsp_word_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready after item accepted");

   a_word_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_aligned_word == '0)
      else $error("nonzero word with failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NONE
                     || rsp_status == ST_FULL))
      else $error("bad status code");
`endif

endmodule

// ===== design/spbl_ram.sv =====
// Generic single-write, single-read table memory with a registered read.
// Depends on nothing; sized by its parameters.
module spbl_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/spbl_seq.sv =====
// Sequencer with the shared compare unit: sorted insert into both tables
// one after the other, and linear bound scans for queries.
// Depends on spbl_pkg.
module spbl_seq
   import spbl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         out_free,
   output res_item_type res_item,
   output ram_req_type  src_ram_req,
   output ram_req_type  tgt_ram_req,
   input  logic [ENT_W-1:0] src_rd_data,
   input  logic [ENT_W-1:0] tgt_rd_data
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_INS_CHK = 6'b000010,
      S_INS_CMP = 6'b000100,
      S_QRY_CHK = 6'b001000,
      S_QRY_CMP = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [ENT_W-1:0]  ent_ff, ent_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic              last_ff, last_in;
   logic              tbl_ff, tbl_in;
   logic              have_ff, have_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [1:0]        status_ff, status_in;

   logic [CNT_W-1:0]  pos_m1;
   logic [CNT_W-1:0]  pos_p1;
   logic [ENT_W-1:0]  rd_data;
   logic [ENT_W-1:0]  cmp_a, cmp_b;
   logic              cmp_lt;
   ram_req_type       ram_req;
   ram_req_type       ram_idle;

   assign pos_m1  = pos_ff - CNT_W'(1);
   assign pos_p1  = pos_ff + CNT_W'(1);
   assign rd_data = tbl_ff ? tgt_rd_data : src_rd_data;

   // shared compare unit
   always_comb begin
      cmp_a = ent_ff;
      cmp_b = rd_data;
      if (state_ff == S_QRY_CMP) begin
         if (last_ff) begin
            cmp_a = {key_ff, {WORD_W{1'b1}}};
            cmp_b = rd_data;
         end else begin
            cmp_a = rd_data;
            cmp_b = {key_ff, {WORD_W{1'b0}}};
         end
      end
   end

   assign cmp_lt = cmp_a < cmp_b;

   assign ram_idle = '0;
   assign src_ram_req = tbl_ff ? ram_idle : ram_req;
   assign tgt_ram_req = tbl_ff ? ram_req : ram_idle;

   assign req_ready = state_ff == S_IDLE;

   assign res_item.valid        = state_ff == S_RESP;
   assign res_item.status       = status_ff;
   assign res_item.aligned_word = word_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      ent_in    = ent_ff;
      key_in    = key_ff;
      last_in   = last_ff;
      tbl_in    = tbl_ff;
      have_in   = have_ff;
      word_in   = word_ff;
      status_in = status_ff;
      ram_req   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in   = '0;
               status_in = ST_OK;
               case (req_item.action)
                  ACT_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_RESP;
                  end
                  ACT_INSERT: begin
                     if (cnt_ff == CNT_W'(MAX_PAIRS)) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        ent_in   = {req_item.source_word, req_item.target_word};
                        tbl_in   = 1'b0;
                        pos_in   = cnt_ff;
                        state_in = S_INS_CHK;
                     end
                  end
                  default: begin
                     tbl_in   = req_item.action == ACT_QTGT;
                     key_in   = (req_item.action == ACT_QTGT) ? req_item.target_word
                                                              : req_item.source_word;
                     last_in  = req_item.rightmost;
                     have_in  = 1'b0;
                     pos_in   = '0;
                     state_in = S_QRY_CHK;
                  end
               endcase
            end
         end
         S_INS_CHK: begin
            if (pos_ff == '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = '0;
               ram_req.wr_data = ent_ff;
               if (tbl_ff) begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = S_RESP;
               end else begin
                  tbl_in = 1'b1;
                  ent_in = {ent_ff[WORD_W-1:0], ent_ff[ENT_W-1:WORD_W]};
                  pos_in = cnt_ff;
               end
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = pos_m1[AW-1:0];
               state_in        = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff[AW-1:0];
            if (cmp_lt) begin
               ram_req.wr_data = rd_data;
               pos_in          = pos_m1;
               state_in        = S_INS_CHK;
            end else begin
               ram_req.wr_data = ent_ff;
               if (tbl_ff) begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = S_RESP;
               end else begin
                  tbl_in   = 1'b1;
                  ent_in   = {ent_ff[WORD_W-1:0], ent_ff[ENT_W-1:WORD_W]};
                  pos_in   = cnt_ff;
                  state_in = S_INS_CHK;
               end
            end
         end
         S_QRY_CHK: begin
            if (pos_ff == cnt_ff) begin
               if (!(last_ff && have_ff)) begin
                  status_in = ST_NONE;
                  word_in   = '0;
               end
               state_in = S_RESP;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = pos_ff[AW-1:0];
               state_in        = S_QRY_CMP;
            end
         end
         S_QRY_CMP: begin
            if (last_ff) begin
               if (cmp_lt) begin
                  if (!have_ff) begin
                     status_in = ST_NONE;
                     word_in   = '0;
                  end
                  state_in = S_RESP;
               end else begin
                  have_in  = 1'b1;
                  word_in  = rd_data[WORD_W-1:0];
                  pos_in   = pos_p1;
                  state_in = S_QRY_CHK;
               end
            end else begin
               if (!cmp_lt) begin
                  word_in  = rd_data[WORD_W-1:0];
                  state_in = S_RESP;
               end else begin
                  pos_in   = pos_p1;
                  state_in = S_QRY_CHK;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      ent_ff    <= ent_in;
      key_ff    <= key_in;
      last_ff   <= last_in;
      tbl_ff    <= tbl_in;
      have_ff   <= have_in;
      word_ff   <= word_in;
      status_ff <= status_in;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_pair_bound_lookup: directed and random clear, insert and bound
// query items checked against an in-bench table of sorted pairs. Depends on spbl_pkg and the DUT.
module tb_top
   import spbl_pkg::*;
();

   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 4 * MAX_PAIRS + 40;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] word;
   } answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action = ACT_CLEAR;
   logic [WORD_W-1:0] req_source_word = '0;
   logic [WORD_W-1:0] req_target_word = '0;
   logic              req_rightmost = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [WORD_W-1:0] rsp_aligned_word;

   logic [ENT_W-1:0]  order_tab [2][MAX_PAIRS];
   int                pair_total = 0;
   answer_type        pending_answers [$];
   int                errors = 0;
   int                n_sent = 0;
   int                cycles = 0;
   bit                steady = 1'b0;
   int                hold_asked = 0;
   int                hold_seen = 0;
   int                hold_left = 0;

   sorted_pair_bound_lookup dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_source_word  (req_source_word),
      .req_target_word  (req_target_word),
      .req_rightmost    (req_rightmost),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_aligned_word (rsp_aligned_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d answers pending", $time, pending_answers.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Table index 0 is ordered by source, index 1 by target.
   function automatic answer_type pair_table_step(logic [1:0] act, logic [WORD_W-1:0] src,
                                                  logic [WORD_W-1:0] tgt, logic rm);
      answer_type       ans;
      logic [ENT_W-1:0] entry;
      logic [WORD_W-1:0] key;
      int               pos;
      int               t;
      int               hit;
      ans.status = ST_OK;
      ans.word   = '0;
      case (act)
         ACT_CLEAR: begin
            pair_total = 0;
         end
         ACT_INSERT: begin
            if (pair_total >= MAX_PAIRS) begin
               ans.status = ST_FULL;
            end else begin
               for (t = 0; t < 2; t++) begin
                  entry = (t == 0) ? {src, tgt} : {tgt, src};
                  pos = pair_total;
                  while (pos > 0 && order_tab[t][pos-1] > entry) begin
                     order_tab[t][pos] = order_tab[t][pos-1];
                     pos--;
                  end
                  order_tab[t][pos] = entry;
               end
               pair_total++;
            end
         end
         default: begin
            t   = (act == ACT_QSRC) ? 0 : 1;
            key = (act == ACT_QSRC) ? src : tgt;
            hit = -1;
            for (pos = 0; pos < pair_total; pos++) begin
               if (!rm && hit < 0 && order_tab[t][pos][ENT_W-1:WORD_W] >= key)
                  hit = pos;
               if (rm && order_tab[t][pos][ENT_W-1:WORD_W] <= key)
                  hit = pos;
            end
            if (hit < 0)
               ans.status = ST_NONE;
            else
               ans.word = order_tab[t][hit][WORD_W-1:0];
         end
      endcase
      return ans;
   endfunction

   // Return at the edge where the item is taken, with valid still high.
   task automatic send_item(logic [1:0] act, logic [WORD_W-1:0] src,
                            logic [WORD_W-1:0] tgt, logic rm);
      while (!steady && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_source_word <= src;
      req_target_word <= tgt;
      req_rightmost   <= rm;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_answers.push_back(pair_table_step(act, src, tgt, rm));
      n_sent++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      return WORD_W'($urandom_range(255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [1:0] rand_query();
      return 2'($urandom_range(ACT_QSRC, ACT_QTGT));
   endfunction

   function automatic logic [WORD_W-1:0] near_key(int t);
      logic [WORD_W-1:0] base;
      if (pair_total == 0)
         return rand_word();
      base = order_tab[t][$urandom_range(pair_total - 1)][ENT_W-1:WORD_W];
      return WORD_W'(int'(base) + int'($urandom_range(2)) - 1);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected item status %0d word %0d", $time, rsp_status,
                     rsp_aligned_word);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
            if (rsp_aligned_word !== want.word) begin
               $display("%0t: aligned_word expected %0d, actual %0d", $time, want.word,
                        rsp_aligned_word);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_item(ACT_QSRC, 8'd0, 8'd0, 1'b0);
      send_item(ACT_QTGT, 8'd0, 8'd255, 1'b1);
      send_item(ACT_INSERT, 8'd10, 8'd20, 1'b0);
      send_item(ACT_INSERT, 8'd10, 8'd20, 1'b0);
      send_item(ACT_INSERT, 8'd10, 8'd5, 1'b0);
      send_item(ACT_INSERT, 8'd10, 8'd30, 1'b0);
      send_item(ACT_INSERT, 8'd0, 8'd255, 1'b1);
      send_item(ACT_INSERT, 8'd255, 8'd0, 1'b0);
      send_item(ACT_INSERT, 8'd255, 8'd255, 1'b0);
      send_item(ACT_INSERT, 8'd0, 8'd0, 1'b0);
      send_item(ACT_QSRC, 8'd10, 8'd0, 1'b0);
      send_item(ACT_QSRC, 8'd10, 8'd0, 1'b1);
      send_item(ACT_QSRC, 8'd0, 8'd77, 1'b0);
      send_item(ACT_QSRC, 8'd255, 8'd0, 1'b1);
      send_item(ACT_QSRC, 8'd11, 8'd0, 1'b0);
      send_item(ACT_QSRC, 8'd254, 8'd0, 1'b1);
      send_item(ACT_QTGT, 8'd0, 8'd255, 1'b0);
      send_item(ACT_QTGT, 8'd255, 8'd0, 1'b1);
      send_item(ACT_QTGT, 8'd0, 8'd21, 1'b0);
      send_item(ACT_CLEAR, 8'd255, 8'd255, 1'b1);
      send_item(ACT_INSERT, 8'd100, 8'd100, 1'b0);
      send_item(ACT_QSRC, 8'd50, 8'd0, 1'b1);
      send_item(ACT_QSRC, 8'd150, 8'd0, 1'b0);
      send_item(ACT_QTGT, 8'd0, 8'd99, 1'b1);
      send_item(ACT_QTGT, 8'd0, 8'd100, 1'b0);
   endtask

   task automatic test_full_table();
      send_item(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
      repeat (MAX_PAIRS)
         send_item(ACT_INSERT, rand_word(), rand_word(), rand_bit());
      repeat (3)
         send_item(ACT_INSERT, rand_word(), rand_word(), rand_bit());
      send_item(ACT_QSRC, 8'd255, 8'd0, 1'b1);
      send_item(ACT_QSRC, 8'd0, 8'd0, 1'b0);
      send_item(ACT_QTGT, 8'd0, 8'd255, 1'b1);
      send_item(ACT_QTGT, 8'd0, 8'd0, 1'b0);
      send_item(ACT_CLEAR, 8'd0, 8'd0, 1'b1);
      send_item(ACT_QSRC, 8'd128, 8'd0, 1'b1);
      send_item(ACT_QTGT, 8'd0, 8'd128, 1'b0);
   endtask

   task automatic test_receiver_hold();
      wait_for_answers();
      hold_asked++;
      repeat (12)
         send_item(ACT_INSERT, rand_word(), rand_word(), 1'b0);
      repeat (12)
         send_item(rand_query(), near_key(0), near_key(1), rand_bit());
      wait_for_answers();
   endtask

   task automatic test_random_sentences();
      int goal;
      int n_ins;
      int n_q;
      int span;
      int sbase;
      int tbase;
      logic [1:0] act;
      goal = n_sent + RANDOM_ITEMS;
      while (n_sent < goal) begin
         steady = (n_sent > goal - 900 && n_sent < goal - 700);
         case ($urandom_range(2))
            0: span = 3;
            1: span = 15;
            default: span = 255;
         endcase
         sbase = $urandom_range(255 - span);
         tbase = $urandom_range(255 - span);
         n_ins = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
         n_q   = $urandom_range(2, 10);
         send_item(ACT_CLEAR, rand_word(), rand_word(), rand_bit());
         repeat (n_ins)
            send_item(ACT_INSERT, WORD_W'(sbase + int'($urandom_range(span))),
                      WORD_W'(tbase + int'($urandom_range(span))), rand_bit());
         repeat (n_q) begin
            act = rand_query();
            if ($urandom_range(9) < 7)
               send_item(act, near_key(0), near_key(1), rand_bit());
            else
               send_item(act, rand_word(), rand_word(), rand_bit());
         end
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(3)), rand_word(), rand_word(), rand_bit());
         if ($urandom_range(19) == 0)
            wait_for_answers();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_receiver_hold();
      test_random_sentences();
      wait_for_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d items: clear, insert, full-table insert, lower-bound and", n_sent);
      $display("rightmost queries by source and target, with stalls on both channels.");
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
